[src/tapbf_pkg.sv]
package tapbf_pkg;

	// Field and register widths
	localparam int FIELD_W     = 12;
	localparam int BASE_W      = 12;
	localparam int SLOPE_W     = 10;
	localparam int POS_W       = 14;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 1;

	// Only the low SAMPLE_BITS bits of a raw field are used
	localparam int SAMPLE_BITS = 12;
	localparam int RAW_W       = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;

	// 2.8 slope
	localparam int SLOPE_SHIFT = 8;
	localparam int PROD_W      = RAW_W + SLOPE_W;
	localparam int SCALED_W    = PROD_W - SLOPE_SHIFT;
	localparam int BOX_W       = ((SCALED_W > BASE_W) ? SCALED_W : BASE_W) + 1;

	// Signed width that holds raw, offset, position and box sums without wrap
	localparam int CALC_W      = ((BOX_W > RAW_W + 1) ? BOX_W : RAW_W + 1) + 3;

	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_THRESHOLD  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SLOPE = 1'b1;

	typedef enum logic [1:0] {
		MODE_TRACK    = 2'd0,
		MODE_HOLD     = 2'd1,
		MODE_RECENTER = 2'd2
	} mode_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v < CALC_W'(POS_MIN)) begin
			r = POS_MIN;
		end else if (v > CALC_W'(POS_MAX)) begin
			r = POS_MAX;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

[src/tapbf_sample_if.sv]
interface tapbf_sample_if;
	logic                            valid;
	logic                            ready;
	logic [tapbf_pkg::FIELD_W-1:0]   tilt_raw;
	logic [tapbf_pkg::FIELD_W-1:0]   pan_raw;
	logic                            recenter_button;
	logic                            hold_button;

	modport source (output valid, tilt_raw, pan_raw, recenter_button, hold_button, input ready);
	modport sink   (input valid, tilt_raw, pan_raw, recenter_button, hold_button, output ready);
endinterface

[src/tapbf_result_if.sv]
interface tapbf_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tapbf_pkg::POS_W-1:0]   tilt_position;
	logic signed [tapbf_pkg::POS_W-1:0]   pan_position;
	tapbf_pkg::mode_t                     filter_mode;

	modport source (output valid, tilt_position, pan_position, filter_mode, input ready);
	modport sink   (input valid, tilt_position, pan_position, filter_mode, output ready);
endinterface

[src/two_axis_pot_backlash_filter_unit.sv]
// An accepted item is captured in the input register and moves on to the result register
// once that is empty or being taken. Throughput: one item per cycle while the result is
// not stalled; the window multiply sits in front of the input register, the deadband
// compare and offset update between it and the result register.
// A stalled result holds the input stage; a new item enters as the old one leaves.
// Reset (arst_n low, asynchronous) clears offsets, positions, both config registers and all valids.
module two_axis_pot_backlash_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tapbf_sample_if.sink                         sample,
	tapbf_result_if.source                       result,
	input  logic                                 cfg_wr_en,
	input  logic [tapbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tapbf_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
	logic [tapbf_pkg::BASE_W-1:0]        base_threshold_q;
	logic [tapbf_pkg::SLOPE_W-1:0]       threshold_slope_q;

	logic                                valid_s1;
	logic [tapbf_pkg::RAW_W-1:0]         tilt_raw_s1;
	logic [tapbf_pkg::RAW_W-1:0]         pan_raw_s1;
	logic [tapbf_pkg::BOX_W-1:0]         tilt_box_s1;
	logic [tapbf_pkg::BOX_W-1:0]         pan_box_s1;
	tapbf_pkg::mode_t                    mode_s1;

	logic                                res_valid_q;
	tapbf_pkg::mode_t                    mode_q;
	logic signed [tapbf_pkg::POS_W-1:0]  tilt_offset_q;
	logic signed [tapbf_pkg::POS_W-1:0]  pan_offset_q;
	logic signed [tapbf_pkg::POS_W-1:0]  tilt_pos_q;
	logic signed [tapbf_pkg::POS_W-1:0]  pan_pos_q;

	logic [tapbf_pkg::RAW_W-1:0]         tilt_raw;
	logic [tapbf_pkg::RAW_W-1:0]         pan_raw;
	logic [tapbf_pkg::BOX_W-1:0]         tilt_box;
	logic [tapbf_pkg::BOX_W-1:0]         pan_box;
	tapbf_pkg::mode_t                    mode_in;
	logic signed [tapbf_pkg::POS_W-1:0]  tilt_offset_nxt;
	logic signed [tapbf_pkg::POS_W-1:0]  pan_offset_nxt;
	logic signed [tapbf_pkg::POS_W-1:0]  tilt_pos_nxt;
	logic signed [tapbf_pkg::POS_W-1:0]  pan_pos_nxt;

	logic                                sample_acc;
	logic                                advance;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_threshold_q  <= '0;
			threshold_slope_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tapbf_pkg::REG_BASE_THRESHOLD:  base_threshold_q  <= cfg_wr_data[tapbf_pkg::BASE_W-1:0];
				tapbf_pkg::REG_THRESHOLD_SLOPE: threshold_slope_q <= cfg_wr_data[tapbf_pkg::SLOPE_W-1:0];
				default: ;
			endcase
		end
	end

	assign tilt_raw = sample.tilt_raw[tapbf_pkg::RAW_W-1:0];
	assign pan_raw  = sample.pan_raw[tapbf_pkg::RAW_W-1:0];

	// recenter wins over hold
	always_comb begin
		if (sample.recenter_button) begin
			mode_in = tapbf_pkg::MODE_RECENTER;
		end else if (sample.hold_button) begin
			mode_in = tapbf_pkg::MODE_HOLD;
		end else begin
			mode_in = tapbf_pkg::MODE_TRACK;
		end
	end

	tapbf_window u_tilt_window (
		.raw             (tilt_raw),
		.base_threshold  (base_threshold_q),
		.threshold_slope (threshold_slope_q),
		.box             (tilt_box)
	);

	tapbf_window u_pan_window (
		.raw             (pan_raw),
		.base_threshold  (base_threshold_q),
		.threshold_slope (threshold_slope_q),
		.box             (pan_box)
	);

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign sample_acc   = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			tilt_raw_s1 <= tilt_raw;
			pan_raw_s1  <= pan_raw;
			tilt_box_s1 <= tilt_box;
			pan_box_s1  <= pan_box;
			mode_s1     <= mode_in;
		end
	end

	tapbf_axis u_tilt_axis (
		.raw        (tilt_raw_s1),
		.box        (tilt_box_s1),
		.mode       (mode_s1),
		.offset     (tilt_offset_q),
		.pos        (tilt_pos_q),
		.offset_nxt (tilt_offset_nxt),
		.pos_nxt    (tilt_pos_nxt)
	);

	tapbf_axis u_pan_axis (
		.raw        (pan_raw_s1),
		.box        (pan_box_s1),
		.mode       (mode_s1),
		.offset     (pan_offset_q),
		.pos        (pan_pos_q),
		.offset_nxt (pan_offset_nxt),
		.pos_nxt    (pan_pos_nxt)
	);

	// positions double as the result payload: they only move when an item advances into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_offset_q <= '0;
			pan_offset_q  <= '0;
			tilt_pos_q    <= '0;
			pan_pos_q     <= '0;
			mode_q        <= tapbf_pkg::MODE_TRACK;
		end else if (advance) begin
			tilt_offset_q <= tilt_offset_nxt;
			pan_offset_q  <= pan_offset_nxt;
			tilt_pos_q    <= tilt_pos_nxt;
			pan_pos_q     <= pan_pos_nxt;
			mode_q        <= mode_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.tilt_position = tilt_pos_q;
	assign result.pan_position  = pan_pos_q;
	assign result.filter_mode   = mode_q;

	a_recenter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && mode_q == tapbf_pkg::MODE_RECENTER)
		|-> (tilt_pos_q == '0 && pan_pos_q == '0))
		else $error("recenter result with non-zero position");

	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 == tapbf_pkg::MODE_HOLD)
		|=> ($stable(tilt_pos_q) && $stable(pan_pos_q)))
		else $error("position moved during hold");

	a_stall_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready)
		|=> ($stable(tilt_pos_q) && $stable(pan_pos_q)
			&& $stable(tilt_offset_q) && $stable(pan_offset_q)))
		else $error("filter state changed while result stalled");

	a_track_keeps_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_s1 == tapbf_pkg::MODE_TRACK)
		|=> ($stable(tilt_offset_q) && $stable(pan_offset_q)))
		else $error("offset changed while tracking");
endmodule

[src/tapbf_window.sv]
// Deadband half-width: base + ((raw * slope) >> 8)
module tapbf_window (
	input  logic [tapbf_pkg::RAW_W-1:0]   raw,
	input  logic [tapbf_pkg::BASE_W-1:0]  base_threshold,
	input  logic [tapbf_pkg::SLOPE_W-1:0] threshold_slope,
	output logic [tapbf_pkg::BOX_W-1:0]   box
);
	logic [tapbf_pkg::PROD_W-1:0] prod;

	assign prod = tapbf_pkg::PROD_W'(raw) * tapbf_pkg::PROD_W'(threshold_slope);
	assign box  = tapbf_pkg::BOX_W'(base_threshold)
		+ tapbf_pkg::BOX_W'(prod[tapbf_pkg::PROD_W-1:tapbf_pkg::SLOPE_SHIFT]);
endmodule

[src/tapbf_axis.sv]
// Next offset and position of one axis
module tapbf_axis (
	input  logic [tapbf_pkg::RAW_W-1:0]         raw,
	input  logic [tapbf_pkg::BOX_W-1:0]         box,
	input  tapbf_pkg::mode_t                    mode,
	input  logic signed [tapbf_pkg::POS_W-1:0]  offset,
	input  logic signed [tapbf_pkg::POS_W-1:0]  pos,
	output logic signed [tapbf_pkg::POS_W-1:0]  offset_nxt,
	output logic signed [tapbf_pkg::POS_W-1:0]  pos_nxt
);
	logic signed [tapbf_pkg::CALC_W-1:0] raw_c;
	logic signed [tapbf_pkg::CALC_W-1:0] off_c;
	logic signed [tapbf_pkg::CALC_W-1:0] pos_c;
	logic signed [tapbf_pkg::CALC_W-1:0] box_c;
	logic signed [tapbf_pkg::CALC_W-1:0] x;
	logic signed [tapbf_pkg::CALC_W-1:0] p;

	assign raw_c = tapbf_pkg::CALC_W'(raw);
	assign box_c = tapbf_pkg::CALC_W'(box);
	assign off_c = tapbf_pkg::CALC_W'(offset);
	assign pos_c = tapbf_pkg::CALC_W'(pos);
	assign x     = raw_c - off_c;

	// position trails the corrected value at the window edge
	always_comb begin
		if (x - pos_c > box_c) begin
			p = x - box_c;
		end else if (pos_c - x > box_c) begin
			p = x + box_c;
		end else begin
			p = pos_c;
		end
	end

	always_comb begin
		case (mode)
			tapbf_pkg::MODE_RECENTER: begin
				offset_nxt = tapbf_pkg::sat_pos(raw_c);
				pos_nxt    = '0;
			end
			tapbf_pkg::MODE_HOLD: begin
				offset_nxt = tapbf_pkg::sat_pos(raw_c - pos_c);
				pos_nxt    = pos;
			end
			tapbf_pkg::MODE_TRACK: begin
				offset_nxt = offset;
				pos_nxt    = tapbf_pkg::sat_pos(p);
			end
			default: begin
				offset_nxt = offset;
				pos_nxt    = pos;
			end
		endcase
	end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int RAW_MAX = (1 << tapbf_pkg::FIELD_W) - 1;

	typedef struct {
		logic [tapbf_pkg::FIELD_W-1:0] tilt_raw;
		logic [tapbf_pkg::FIELD_W-1:0] pan_raw;
		logic                          recenter;
		logic                          hold;
	} sample_t;

	typedef struct {
		logic signed [tapbf_pkg::POS_W-1:0] tilt;
		logic signed [tapbf_pkg::POS_W-1:0] pan;
		tapbf_pkg::mode_t                   mode;
	} position_t;

	typedef enum {ROW_ITEM, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		sample_t                           s;
		logic [tapbf_pkg::CFG_INDEX_W-1:0] reg_index;
		logic [tapbf_pkg::CFG_DATA_W-1:0]  reg_value;
		bit                                known;
		position_t                         want;
	} row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic [tapbf_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [tapbf_pkg::CFG_DATA_W-1:0]  cfg_wr_data;

	tapbf_sample_if sample_ch();
	tapbf_result_if result_ch();

	two_axis_pot_backlash_filter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state
	logic [tapbf_pkg::BASE_W-1:0]       base_reg;
	logic [tapbf_pkg::SLOPE_W-1:0]      slope_reg;
	logic signed [tapbf_pkg::POS_W-1:0] tilt_zero;
	logic signed [tapbf_pkg::POS_W-1:0] pan_zero;
	logic signed [tapbf_pkg::POS_W-1:0] tilt_track;
	logic signed [tapbf_pkg::POS_W-1:0] pan_track;

	position_t                     expected_positions[$];
	row_t                          steps[$];
	logic [tapbf_pkg::FIELD_W-1:0] tilt_last;
	logic [tapbf_pkg::FIELD_W-1:0] pan_last;

	int errors         = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int recenters      = 0;
	int holds          = 0;
	int tracks         = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	bit long_hold_req  = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [tapbf_pkg::POS_W-1:0] clamp_pos(int v);
		if (v < int'(tapbf_pkg::POS_MIN)) return tapbf_pkg::POS_MIN;
		if (v > int'(tapbf_pkg::POS_MAX)) return tapbf_pkg::POS_MAX;
		return tapbf_pkg::POS_W'(v);
	endfunction

	function automatic logic signed [tapbf_pkg::POS_W-1:0] deadband(int raw,
			logic signed [tapbf_pkg::POS_W-1:0] zero,
			logic signed [tapbf_pkg::POS_W-1:0] track);
		int window;
		int x;
		int p;
		window = int'(base_reg) + ((raw * int'(slope_reg)) >> tapbf_pkg::SLOPE_SHIFT);
		x = raw - int'(zero);
		p = int'(track);
		// position trails the corrected value at the window edge
		if (x - p > window) begin
			p = x - window;
		end else if (p - x > window) begin
			p = x + window;
		end
		return clamp_pos(p);
	endfunction

	function automatic position_t backlash_step(sample_t s);
		int        tr;
		int        pr;
		position_t r;
		tr = int'(s.tilt_raw[tapbf_pkg::RAW_W-1:0]);
		pr = int'(s.pan_raw[tapbf_pkg::RAW_W-1:0]);
		if (s.recenter) begin
			tilt_zero = clamp_pos(tr);
			pan_zero = clamp_pos(pr);
			tilt_track = '0;
			pan_track = '0;
			r.mode = tapbf_pkg::MODE_RECENTER;
		end else if (s.hold) begin
			tilt_zero = clamp_pos(tr - int'(tilt_track));
			pan_zero = clamp_pos(pr - int'(pan_track));
			r.mode = tapbf_pkg::MODE_HOLD;
		end else begin
			tilt_track = deadband(tr, tilt_zero, tilt_track);
			pan_track = deadband(pr, pan_zero, pan_track);
			r.mode = tapbf_pkg::MODE_TRACK;
		end
		r.tilt = tilt_track;
		r.pan = pan_track;
		return r;
	endfunction

	function automatic logic [tapbf_pkg::FIELD_W-1:0] pick_raw(
			logic [tapbf_pkg::FIELD_W-1:0] last);
		int sel;
		int v;
		int reach;
		sel = $urandom_range(99);
		if (sel < 10) begin
			v = $urandom_range(1) ? RAW_MAX : 0;
		end else if (sel < 45) begin
			v = $urandom_range(RAW_MAX);
		end else begin
			// wander around the last sample to work the deadband edges
			reach = 1 << $urandom_range(11);
			v = int'(last) + int'($urandom_range(2 * reach)) - reach;
			if (v < 0) begin
				v = 0;
			end else if (v > RAW_MAX) begin
				v = RAW_MAX;
			end
		end
		return tapbf_pkg::FIELD_W'(v);
	endfunction

	function automatic void add_item(int t, int p, bit rc, bit hd, bit known = 1'b0,
			int et = 0, int ep = 0, tapbf_pkg::mode_t em = tapbf_pkg::MODE_TRACK);
		row_t r;
		r.kind = ROW_ITEM;
		r.s.tilt_raw = tapbf_pkg::FIELD_W'(t);
		r.s.pan_raw = tapbf_pkg::FIELD_W'(p);
		r.s.recenter = rc;
		r.s.hold = hd;
		r.reg_index = tapbf_pkg::REG_BASE_THRESHOLD;
		r.reg_value = '0;
		r.known = known;
		r.want.tilt = tapbf_pkg::POS_W'(et);
		r.want.pan = tapbf_pkg::POS_W'(ep);
		r.want.mode = em;
		steps.push_back(r);
	endfunction

	function automatic void add_config(logic [tapbf_pkg::CFG_INDEX_W-1:0] idx, int value);
		row_t r;
		r.kind = ROW_CONFIG;
		r.s.tilt_raw = '0;
		r.s.pan_raw = '0;
		r.s.recenter = 1'b0;
		r.s.hold = 1'b0;
		r.reg_index = idx;
		r.reg_value = tapbf_pkg::CFG_DATA_W'(value);
		r.known = 1'b0;
		steps.push_back(r);
	endfunction

	task automatic offer(sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.tilt_raw <= s.tilt_raw;
		sample_ch.pan_raw <= s.pan_raw;
		sample_ch.recenter_button <= s.recenter;
		sample_ch.hold_button <= s.hold;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		items_sent++;
		if (s.recenter) begin
			recenters++;
		end else if (s.hold) begin
			holds++;
		end else begin
			tracks++;
		end
	endtask

	// leaves the write enable high; the caller drops it
	task automatic write_reg(logic [tapbf_pkg::CFG_INDEX_W-1:0] idx, int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= tapbf_pkg::CFG_DATA_W'(value);
		if (idx == tapbf_pkg::REG_BASE_THRESHOLD) begin
			base_reg = tapbf_pkg::BASE_W'(value);
		end else begin
			slope_reg = tapbf_pkg::SLOPE_W'(value);
		end
		@(posedge clk);
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
	endtask

	initial begin
		row_t      row;
		sample_t   s;
		position_t pred;
		int        bthr;
		int        slp;
		int        sel;
		sample_ch.valid <= 1'b0;
		sample_ch.tilt_raw <= '0;
		sample_ch.pan_raw <= '0;
		sample_ch.recenter_button <= 1'b0;
		sample_ch.hold_button <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= tapbf_pkg::REG_BASE_THRESHOLD;
		cfg_wr_data <= '0;
		arst_n <= 1'b0;
		base_reg = '0;
		slope_reg = '0;
		tilt_zero = '0;
		pan_zero = '0;
		tilt_track = '0;
		pan_track = '0;
		tilt_last = '0;
		pan_last = '0;

		// zero-width window: position equals the corrected sample, clamped to the position range
		add_item(0, 0, 0, 0, 1, 0, 0, tapbf_pkg::MODE_TRACK);
		add_item(4095, 4095, 0, 0, 1, 4095, 4095, tapbf_pkg::MODE_TRACK);
		add_item(0, 0, 0, 1, 1, 4095, 4095, tapbf_pkg::MODE_HOLD);
		add_item(4095, 4095, 0, 0, 1, 8190, 8190, tapbf_pkg::MODE_TRACK);
		add_item(0, 0, 0, 1, 1, 8190, 8190, tapbf_pkg::MODE_HOLD);
		add_item(4095, 4095, 0, 0, 1, 8191, 8191, tapbf_pkg::MODE_TRACK);
		add_item(0, 0, 0, 1, 1, 8191, 8191, tapbf_pkg::MODE_HOLD);
		// both buttons: recenter wins
		add_item(4095, 0, 1, 1, 1, 0, 0, tapbf_pkg::MODE_RECENTER);
		add_item(4095, 4095, 1, 0, 1, 0, 0, tapbf_pkg::MODE_RECENTER);
		add_item(0, 0, 0, 0, 1, -4095, -4095, tapbf_pkg::MODE_TRACK);
		add_item(4095, 4095, 0, 1, 1, -4095, -4095, tapbf_pkg::MODE_HOLD);
		add_item(0, 0, 0, 0, 1, -8190, -8190, tapbf_pkg::MODE_TRACK);
		// offset saturates on this hold
		add_item(4095, 4095, 0, 1, 1, -8190, -8190, tapbf_pkg::MODE_HOLD);
		add_item(0, 0, 0, 0, 1, -8191, -8191, tapbf_pkg::MODE_TRACK);
		add_config(tapbf_pkg::REG_BASE_THRESHOLD, 4095);
		add_config(tapbf_pkg::REG_THRESHOLD_SLOPE, 1023);
		add_item(2048, 1024, 1, 0, 1, 0, 0, tapbf_pkg::MODE_RECENTER);
		add_item(0, 4095, 0, 0);
		add_item(4095, 0, 0, 0);
		add_item(1234, 3000, 0, 1);
		add_config(tapbf_pkg::REG_BASE_THRESHOLD, 0);
		add_item(4095, 4095, 0, 0);
		add_item(0, 0, 0, 0);
		add_item(0, 0, 1, 0, 1, 0, 0, tapbf_pkg::MODE_RECENTER);
		add_item(12'hAAA, 12'h555, 0, 0);
		add_item(12'h555, 12'hAAA, 0, 0);
		add_item(100, 4000, 0, 1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		sink_stall_pct = 30;

		foreach (steps[i]) begin
			row = steps[i];
			if (row.kind == ROW_CONFIG) begin
				settle();
				write_reg(row.reg_index, row.reg_value);
			end else begin
				cfg_wr_en <= 1'b0;
				offer(row.s);
				s = row.s;
				// the predictor steps on every item row, known or not, so its state stays in line
				pred = backlash_step(s);
				expected_positions.push_back(row.known ? row.want : pred);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					bthr = 0; slp = 0; src_idle_pct = 0; sink_stall_pct = 0;
				end
				1: begin
					bthr = 4095; slp = 1023; src_idle_pct = 75; sink_stall_pct = 0;
				end
				2: begin
					bthr = $urandom_range(63); slp = $urandom_range(1023);
					src_idle_pct = 0; sink_stall_pct = 75;
				end
				3: begin
					bthr = $urandom_range(4095); slp = 0;
					src_idle_pct = 36; sink_stall_pct = 36;
				end
				4: begin
					bthr = 0; slp = 1023; src_idle_pct = 0; sink_stall_pct = 0;
				end
				default: begin
					bthr = $urandom_range(255); slp = $urandom_range(255);
					src_idle_pct = 36; sink_stall_pct = 36;
				end
			endcase
			settle();
			write_reg(tapbf_pkg::REG_BASE_THRESHOLD, bthr);
			write_reg(tapbf_pkg::REG_THRESHOLD_SLOPE, slp);
			cfg_wr_en <= 1'b0;
			// sender keeps offering items while the result side is held off
			if (ph == 0) long_hold_req = 1'b1;
			for (int n = 0; n < 200; n++) begin
				s.tilt_raw = pick_raw(tilt_last);
				s.pan_raw = pick_raw(pan_last);
				tilt_last = s.tilt_raw;
				pan_last = s.pan_raw;
				sel = $urandom_range(99);
				s.recenter = (sel < 6);
				s.hold = (sel < 3) || (sel >= 6 && sel < 22);
				offer(s);
				expected_positions.push_back(backlash_step(s));
			end
		end
		settle();
		repeat (8) @(posedge clk);

		$display("Sent %0d items (%0d tracking, %0d hold, %0d recenter), checked %0d results",
			items_sent, tracks, holds, recenters, results_seen);
		$display("over six window settings including both extremes and four idling mixes");
		if (errors == 0) begin
			$display("two_axis_pot_backlash_filter_unit regression: pass");
		end else begin
			$display("two_axis_pot_backlash_filter_unit regression: fail");
		end
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				result_ch.ready <= 1'b0;
				for (int c = 0; c < 300; c++) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		position_t want;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				results_seen++;
				if (expected_positions.size() == 0) begin
					errors++;
					$display("%0t: unexpected item: tilt %0d pan %0d mode %0d", $time,
						result_ch.tilt_position, result_ch.pan_position, result_ch.filter_mode);
				end else begin
					want = expected_positions.pop_front();
					if (result_ch.tilt_position !== want.tilt) begin
						errors++;
						$display("%0t: tilt_position expected %0d, got %0d", $time,
							want.tilt, result_ch.tilt_position);
					end
					if (result_ch.pan_position !== want.pan) begin
						errors++;
						$display("%0t: pan_position expected %0d, got %0d", $time,
							want.pan, result_ch.pan_position);
					end
					if (result_ch.filter_mode !== want.mode) begin
						errors++;
						$display("%0t: filter_mode expected %0d, got %0d", $time,
							want.mode, result_ch.filter_mode);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("%0t: timed out with %0d items outstanding", $time, expected_positions.size());
		$display("two_axis_pot_backlash_filter_unit regression: fail");
		$finish;
	end

endmodule
